>>> src/aip_pkg.sv
// Shared types and constants for the ASCII integer parser.
// Used by the front classifier, the item queue, the back executor and the top level.
package aip_pkg;

	// Character codes that the parser treats specially.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_X   = 8'h78;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned DIGIT_W = 4;

	// Offset that maps the low nibble of 'a'..'f' or 'A'..'F' onto 10..15.
	localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd9;

	// Syntax mode register values.
	localparam logic MODE_HEX     = 1'b0;
	localparam logic MODE_DEC_0X  = 1'b1;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_ZERO   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_STOP   = 3'd3
	} phase_t;

	// Classified character as it travels from the front to the back.
	typedef struct packed {
		logic                term;
		logic                blank;
		logic                dec;
		logic                hex_letter;
		logic                hash;
		logic                x_char;
		logic [DIGIT_W-1:0]  digit;
	} char_class_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> src/ascii_integer_parser_core.sv
// Top level of the ASCII integer parser: front classifier, item queue, back executor.
// Depends on aip_pkg, aip_front, aip_fifo and aip_back.

// The parser takes one text character per item on the s_ side and returns the
// parsed 64-bit value on the m_ side when the terminating code 0 arrives; all
// other characters give no result. Leading whitespace is skipped; syntax mode 0
// reads hexadecimal with an optional 0x, 0X or # prefix, mode 1 reads
// hexadecimal after 0x or 0X and decimal otherwise. Parsing stops at the first
// character that is not a digit and the rest of the string is ignored; the
// value wraps modulo 2^64. Throughput is one item per clock cycle while the
// queue is not full: the front classifies a character in the cycle it is
// accepted and writes it into a FIFO_DEPTH-entry queue, and the back updates
// the accumulator with one shift-and-add per cycle. The back takes characters
// from the head of the queue, and a terminator's value is loaded into the
// output register at the edge that takes it from the queue; m_tvalid comes from
// that register and the value stays on m_tdata until it is taken.
// While a terminator waits for the output register to be taken, the queue
// holds up to FIFO_DEPTH items, the waiting terminator included, before the
// input stalls. Write syntax_mode only while no string is in flight.
module ascii_integer_parser_core #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: syntax_mode register.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_wdata,   // bit 0: syntax_mode
	// Input characters.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // bits 7:0: char_code
	// Parsed results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata      // bits 63:0: value
);
	import aip_pkg::*;

	logic        syntax_mode_q;
	char_class_t in_cls;
	char_class_t head_cls;
	fifo_stat_t  q_stat;
	logic        push;
	logic        pop;

	// The mode register is sampled by the back when a string starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syntax_mode_q <= MODE_HEX;
		end else if (cfg_we) begin
			syntax_mode_q <= cfg_wdata[0];
		end
	end

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	aip_front u_front (
		.char_code (s_tdata),
		.cls       (in_cls)
	);

	aip_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (in_cls),
		.pop     (pop),
		.rd_item (head_cls),
		.stat    (q_stat)
	);

	aip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.syntax_mode (syntax_mode_q),
		.head_valid  (!q_stat.empty),
		.head        (head_cls),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// The queue can never report full and empty at once.
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// A terminator is never consumed while a result waits untaken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cls.term) |-> !(m_tvalid && !m_tready))
		else $error("result overwritten before it was taken");

	// A new result appears only after a terminator left the queue.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(pop && head_cls.term))
		else $error("result raised without a terminator");

	// Nothing is taken from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

endmodule

>>> src/aip_front.sv
// Front part of the ASCII integer parser: classifies each incoming character.
// Depends on aip_pkg.
module aip_front (
	input  logic [7:0]          char_code,
	output aip_pkg::char_class_t cls
);
	import aip_pkg::*;

	logic is_upper;
	logic is_lower;

	always_comb begin
		is_upper       = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
		is_lower       = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
		cls.term       = (char_code == CH_NUL);
		cls.blank      = ((char_code >= CH_TAB) && (char_code <= CH_CR)) ||
		                 (char_code == CH_SPACE);
		cls.dec        = (char_code >= CH_DIG_0) && (char_code <= CH_DIG_9);
		cls.hex_letter = is_upper || is_lower;
		cls.hash       = (char_code == CH_HASH);
		cls.x_char     = (char_code == CH_LO_X) || (char_code == CH_UP_X);
		// Digits keep their low nibble; letters a-f map from 1..6 up to 10..15.
		if (cls.hex_letter) begin
			cls.digit = char_code[DIGIT_W-1:0] + HEX_LETTER_OFS;
		end else begin
			cls.digit = char_code[DIGIT_W-1:0];
		end
	end

endmodule

>>> src/aip_fifo.sv
// Short queue of classified characters between the parser front and back.
// Depends on aip_pkg.
module aip_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  aip_pkg::char_class_t wr_item,
	input  logic                 pop,
	output aip_pkg::char_class_t rd_item,
	output aip_pkg::fifo_stat_t  stat
);
	import aip_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	char_class_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_item    = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/aip_back.sv
// Back part of the ASCII integer parser: phase machine, accumulator and result register.
// Depends on aip_pkg.
module aip_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           syntax_mode,
	input  logic                           head_valid,
	input  aip_pkg::char_class_t           head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [aip_pkg::VALUE_W-1:0]    m_tdata
);
	import aip_pkg::*;

	phase_t               phase_q, phase_d;
	logic [VALUE_W-1:0]   acc_q, acc_d;
	logic                 hex_q, hex_d;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_data_q;

	logic                 out_free;
	logic                 emit;
	logic                 use_hex;
	logic [VALUE_W-1:0]   acc_base;
	logic [VALUE_W-1:0]   acc_next_digit;
	logic                 digit_ok;

	assign out_free = !out_valid_q || m_tready;
	// A terminator needs room in the result register; other items always proceed.
	assign pop      = head_valid && (!head.term || out_free);
	assign emit     = pop && head.term;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		// In the skip phase the radix and a cleared accumulator are chosen here.
		use_hex  = (phase_q == PH_SKIP) ? (syntax_mode == MODE_HEX) : hex_q;
		acc_base = (phase_q == PH_SKIP) ? '0 : acc_q;
		digit_ok = head.dec || (use_hex && head.hex_letter);
		if (use_hex) begin
			acc_next_digit = {acc_base[VALUE_W-5:0], head.digit};
		end else begin
			acc_next_digit = {acc_base[VALUE_W-4:0], 3'b000} +
			                 {acc_base[VALUE_W-2:0], 1'b0} +
			                 VALUE_W'(head.digit);
		end
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		hex_d   = hex_q;
		if (pop) begin
			if (head.term) begin
				phase_d = PH_SKIP;
				acc_d   = '0;
				hex_d   = 1'b0;
			end else begin
				unique case (phase_q)
					PH_SKIP: begin
						if (!head.blank) begin
							hex_d = use_hex;
							acc_d = '0;
							if (head.dec && (head.digit == '0)) begin
								phase_d = PH_ZERO;
							end else if (head.hash && (syntax_mode == MODE_HEX)) begin
								phase_d = PH_DIGITS;
							end else if (digit_ok) begin
								acc_d   = acc_next_digit;
								phase_d = PH_DIGITS;
							end else begin
								phase_d = PH_STOP;
							end
						end
					end
					PH_ZERO: begin
						if (head.x_char) begin
							hex_d   = 1'b1;
							acc_d   = '0;
							phase_d = PH_DIGITS;
						end else if (digit_ok) begin
							acc_d   = acc_next_digit;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_STOP;
						end
					end
					PH_DIGITS: begin
						if (digit_ok) begin
							acc_d = acc_next_digit;
						end else begin
							phase_d = PH_STOP;
						end
					end
					default: begin
						phase_d = PH_STOP;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			acc_q       <= '0;
			hex_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			hex_q   <= hex_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= acc_q;
		end
	end

endmodule

>>> sim/tb.sv
// Self-checking testbench for ascii_integer_parser_core: streams text strings into the
// parser and compares every parsed value with a cycle-free shadow parser kept in the bench.
// Depends on aip_pkg and the ascii_integer_parser_core RTL.
`timescale 1ns / 100ps

module tb;
	import aip_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int BATCH_ITEMS   = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // bits 7:0: char_code
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;     // bits 63:0: value

	// Shadow copy of the parser state, advanced once per accepted item.
	phase_t      shadow_phase;
	logic [63:0] shadow_acc;
	bit          shadow_hex;
	logic        shadow_mode;

	logic [63:0] pending_values[$];
	logic [63:0] want_value;
	int          errors;
	int          chars_sent;
	int          cycle_count;

	// Idle controls shared between the stimulus and the result sink.
	bit          src_gaps;
	bit          sink_gaps;
	int          sink_hold;

	ascii_integer_parser_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int digit_of(input logic [7:0] c, input bit hex);
		if (c >= CH_DIG_0 && c <= CH_DIG_9)
			return int'(c - CH_DIG_0);
		if (hex && c >= CH_LO_A && c <= CH_LO_F)
			return int'(c - CH_LO_A) + 10;
		if (hex && c >= CH_UP_A && c <= CH_UP_F)
			return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	// A digit in the current radix is shifted in; anything else stops the string.
	task automatic fold_digit(input logic [7:0] c);
		int dv;
		dv = digit_of(c, shadow_hex);
		if (dv < 0) begin
			shadow_phase = PH_STOP;
		end else begin
			shadow_acc = shadow_acc * (shadow_hex ? 64'd16 : 64'd10) + 64'(dv);
			shadow_phase = PH_DIGITS;
		end
	endtask

	// Advances the shadow parser by one character and queues the value on a terminator.
	task automatic parse_char(input logic [7:0] c);
		if (c == CH_NUL) begin
			pending_values.push_back(shadow_acc);
			shadow_phase = PH_SKIP;
			shadow_acc = '0;
			shadow_hex = 1'b0;
		end else begin
			case (shadow_phase)
				PH_SKIP: begin
					if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
						// The mode is only looked at when the first visible character arrives.
						shadow_hex = (shadow_mode == MODE_HEX);
						shadow_acc = '0;
						if (c == CH_DIG_0)
							shadow_phase = PH_ZERO;
						else if (c == CH_HASH && shadow_mode == MODE_HEX)
							shadow_phase = PH_DIGITS;
						else
							fold_digit(c);
					end
				end
				PH_ZERO: begin
					if (c == CH_LO_X || c == CH_UP_X) begin
						shadow_hex = 1'b1;
						shadow_acc = '0;
						shadow_phase = PH_DIGITS;
					end else begin
						fold_digit(c);
					end
				end
				PH_DIGITS: fold_digit(c);
				default: shadow_phase = PH_STOP;
			endcase
		end
	endtask

	// Offers one item and returns at the edge that accepts it. The valid stays high
	// unless a gap follows, so back-to-back items never see valid toggled in one step.
	task automatic send_char(input logic [7:0] c);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_char(c);
		chars_sent++;
		if (src_gaps && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit with_nul = 1'b1);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		if (with_nul)
			send_char(CH_NUL);
	endtask

	// Stops sending, waits for every queued value, then lets the pipeline empty out,
	// since characters without a terminator leave nothing to wait for.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_syntax_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_mode = m;
	endtask

	task automatic test_hex_syntax();
		set_syntax_mode(MODE_HEX);
		send_text("");              // empty string gives zero
		send_text(" #fA");          // blank, hash prefix, mixed-case letters
		send_text("0Xa");           // upper-case prefix
		send_text("\01509z8");      // carriage return, leading zero as digit, early stop
		send_char(8'hFF);           // top code is not a digit
		send_char(CH_NUL);
		wait_for_results();
	endtask

	task automatic test_decimal_syntax();
		set_syntax_mode(MODE_DEC_0X);
		send_text("#5");            // hash is not a prefix in this mode
		send_text("0x");            // prefix with no digits
		send_text("\t99a");         // decimal stops at a letter
		send_text("0x1f");          // prefix switches to hex
		wait_for_results();
	endtask

	// The radix is fixed when a string starts; a later write must not change it.
	task automatic test_mode_change_midstring();
		set_syntax_mode(MODE_HEX);
		send_text("1", 1'b0);
		wait_for_results();
		set_syntax_mode(MODE_DEC_0X);
		send_text("f");
		wait_for_results();
	endtask

	// Seventeen hex digits push the top digit out of the 64-bit value.
	task automatic test_wraparound();
		set_syntax_mode(MODE_HEX);
		send_text("ffffffffffffffff");
		send_text("FFFFFFFFFFFFFFFF1");
		wait_for_results();
		set_syntax_mode(MODE_DEC_0X);
		send_text("99999999999999999999");
		wait_for_results();
	endtask

	// The sink holds off while the source keeps offering short strings, so the
	// internal queue fills and the input side has to stall.
	task automatic test_backpressure();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		sink_hold = 120;
		for (int i = 0; i < 30; i++) begin
			send_char(CH_DIG_0 + 8'($urandom_range(0, 9)));
			send_char(CH_NUL);
		end
		wait_for_results();
	endtask

	// Mostly well-formed strings with random content, the rest noise and raw bytes.
	task automatic test_random_strings();
		int          start;
		int          next_switch;
		int          batch;
		int          kind;
		int          ndig;
		int          r;
		bit          hex_digits;
		logic [7:0]  c;
		string       hex_chars;
		hex_chars   = "0123456789abcdefABCDEF";
		start       = chars_sent;
		next_switch = start;
		batch       = 0;
		while (chars_sent - start < RANDOM_ITEMS) begin
			if (chars_sent >= next_switch) begin
				wait_for_results();
				set_syntax_mode(batch[0] ? MODE_DEC_0X : MODE_HEX);
				// Every third batch runs with no idling on either side.
				src_gaps    = (batch % 3 != 0);
				sink_gaps   = (batch % 3 != 0);
				next_switch = chars_sent + BATCH_ITEMS;
				batch++;
			end
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				repeat ($urandom_range(0, 2)) begin
					r = $urandom_range(0, 5);
					send_char(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
				end
				r = $urandom_range(0, shadow_mode == MODE_HEX ? 3 : 2);
				hex_digits = (shadow_mode == MODE_HEX) || r == 1 || r == 2;
				case (r)
					1: send_text("0x", 1'b0);
					2: send_text("0X", 1'b0);
					3: send_char(CH_HASH);
					default: ;
				endcase
				r = $urandom_range(0, 99);
				ndig = (r < 85) ? $urandom_range(1, 6) :
					(r < 95) ? $urandom_range(7, 16) : $urandom_range(16, 21);
				repeat (ndig) begin
					if (hex_digits)
						c = hex_chars[$urandom_range(0, 21)];
					else
						c = CH_DIG_0 + 8'($urandom_range(0, 9));
					send_char(c);
				end
				if ($urandom_range(0, 99) < 20) begin
					repeat ($urandom_range(1, 4))
						send_char(8'($urandom_range(1, 255)));
				end
				send_char(CH_NUL);
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 8))
					send_char(8'($urandom_range(1, 255)));
				send_char(CH_NUL);
			end else begin
				send_char(8'($urandom_range(0, 255)));
			end
		end
		wait_for_results();
	endtask

	// Result sink: random stalls, or one long hold-off when the stimulus asks for it.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
				m_tready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
				m_tready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each accepted value is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_values.size() == 0) begin
				errors++;
				$display("%0t: unexpected value, expected none, actual %h", $time, m_tdata);
			end else begin
				want_value = pending_values.pop_front();
				if (m_tdata !== want_value) begin
					errors++;
					$display("%0t: value mismatch, expected %h, actual %h",
						$time, want_value, m_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ascii_integer_parser_core regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		errors       = 0;
		chars_sent   = 0;
		cycle_count  = 0;
		src_gaps     = 1'b1;
		sink_gaps    = 1'b1;
		sink_hold    = 0;
		shadow_phase = PH_SKIP;
		shadow_acc   = '0;
		shadow_hex   = 1'b0;
		shadow_mode  = MODE_HEX;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_hex_syntax();
		test_decimal_syntax();
		test_mode_change_midstring();
		test_wraparound();
		test_backpressure();
		test_random_strings();

		if (errors == 0)
			$display("ascii_integer_parser_core regression: pass");
		else
			$display("ascii_integer_parser_core regression: fail");
		$finish;
	end

endmodule
